// ===== rtl/rlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pkg
// types and blend arithmetic shared by the layer compositor
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  // red sits in the lowest byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic   last_layer;
    logic   first_layer;
    logic   has_alpha;
    pixel_t src;
  } layer_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // floor(src * a / 255) + floor(dst * (255 - a) / 255), saturated
  function automatic logic [7:0] blend_ch(input logic [7:0] src, input logic [7:0] dst,
                                          input logic [7:0] a);
    logic [15:0] ps;
    logic [15:0] pd;
    logic [8:0]  v;
    ps = {8'd0, src} * {8'd0, a};
    pd = {8'd0, dst} * {8'd0, 8'(ALPHA_FULL - a)};
    v  = {1'b0, div255(ps)} + {1'b0, div255(pd)};
    return v[8] ? ALPHA_FULL : v[7:0];
  endfunction

endpackage

// ===== rtl/rlc_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_blend
// next accumulator value for one layer pixel applied over the accumulator
// ----------------------------------------------------------------------------
module rlc_blend (
  input  rlc_pkg::layer_t lyr,
  input  rlc_pkg::pixel_t acc,
  output rlc_pkg::pixel_t acc_nxt
);

  rlc_pkg::pixel_t base;
  logic [8:0]      alpha_sum;

  always_comb begin
    base      = lyr.first_layer ? '0 : acc;
    alpha_sum = {1'b0, base.alpha} + {1'b0, lyr.src.alpha};
    acc_nxt   = base;
    if (!lyr.has_alpha) begin
      acc_nxt.red   = lyr.src.red;
      acc_nxt.green = lyr.src.green;
      acc_nxt.blue  = lyr.src.blue;
      acc_nxt.alpha = rlc_pkg::ALPHA_FULL;
    end else if (lyr.src.alpha != 8'd0) begin
      acc_nxt.red   = rlc_pkg::blend_ch(lyr.src.red, base.red, lyr.src.alpha);
      acc_nxt.green = rlc_pkg::blend_ch(lyr.src.green, base.green, lyr.src.alpha);
      acc_nxt.blue  = rlc_pkg::blend_ch(lyr.src.blue, base.blue, lyr.src.alpha);
      acc_nxt.alpha = alpha_sum[8] ? rlc_pkg::ALPHA_FULL : alpha_sum[7:0];
    end
  end

endmodule

// ===== rtl/rgba_layer_compositor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_layer_compositor_unit
// alpha-over compositing of a run of layer pixels into one rgba8 pixel
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  in_     | slave     | one layer pixel per request, tlast ends the pixel
//  out_    | master    | one composited pixel per last layer
//
//  one layer per cycle sustained unless a held result stalls the input; a
//  result is offered once its last layer moves from input to result register
//  the accumulator loads as layers advance, so layers may follow back to back
//  rst_n is synchronous and clears the accumulator and both valid flags
//  a last layer waits in the input register only while a result is held
// ----------------------------------------------------------------------------
module rgba_layer_compositor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // src_red, src_green, src_blue, src_alpha
  input  logic [1:0]  in_tuser,   // has_alpha, first_layer
  input  logic        in_tlast,   // last_layer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // out_red, out_green, out_blue, out_alpha
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  rlc_pkg::layer_t s1_r;
  rlc_pkg::pixel_t acc_r;
  rlc_pkg::pixel_t acc_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  rlc_pkg::pixel_t out_r;
  logic            in_fire;
  logic            s1_adv;
  logic            out_load;

  assign s1_adv    = s1_valid_r && (!s1_r.last_layer || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = s1_adv && s1_r.last_layer;

  rlc_blend u_blend (
    .lyr     (s1_r),
    .acc     (acc_r),
    .acc_nxt (acc_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.src         <= in_tdata;
      s1_r.has_alpha   <= in_tuser[0];
      s1_r.first_layer <= in_tuser[1];
      s1_r.last_layer  <= in_tlast;
    end
    if (out_load) begin
      out_r <= acc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

// ===== rtl/rlc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_props
// port-level checks on the layer compositor, bound to the top level
// ----------------------------------------------------------------------------
module rlc_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  // a held result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a new result is offered only after a last layer has passed the input register
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last layer");

  // the input only stalls behind a held result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with no result pending");

endmodule

bind rgba_layer_compositor_unit rlc_props u_rlc_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
